// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the generational handle allocator modules.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Pool geometry. These follow the fixed field widths of the transactions.
  localparam int SLOTS      = 64;
  localparam int GEN_BITS   = 16;
  localparam int MASK_BITS  = 16;
  localparam int IDX_BITS   = $clog2(SLOTS);
  localparam int COUNT_BITS = $clog2(SLOTS + 1);

  // Bit 0 of a stored mask marks the slot as alive.
  localparam logic [MASK_BITS-1:0] ALIVE_MASK = MASK_BITS'(1);

  typedef enum logic {
    ACTION_ALLOC   = 1'b0,
    ACTION_RELEASE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [IDX_BITS-1:0]   slot_index;
    logic [MASK_BITS-1:0]  type_mask;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_BITS-1:0]    handle_index;
    logic [GEN_BITS-1:0]    handle_generation;
    logic [MASK_BITS-1:0]   stored_mask;
    logic [COUNT_BITS-1:0]  live_count;
  } rsp_t;

  // One slot entry as held in the slot memory.
  typedef struct packed {
    logic [GEN_BITS-1:0]  gen;
    logic [MASK_BITS-1:0] mask;
  } entry_t;

  // Lowest free slot as found by the free finder.
  typedef struct packed {
    logic                none;
    logic [IDX_BITS-1:0] idx;
  } free_t;

endpackage

// ===== rtl/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gha_free_finder.sv =====
// ----------------------------------------------------------------------------
// gha_free_finder
// Finds the lowest-numbered free slot in the live map, in two levels of
// eight-way priority encoding.
// ----------------------------------------------------------------------------
module gha_free_finder (
  input  logic [gha_pkg::SLOTS-1:0] live,
  output gha_pkg::free_t            free
);

  localparam int GROUP     = 8;
  localparam int LOW_BITS  = $clog2(GROUP);
  localparam int NGROUPS   = gha_pkg::SLOTS / GROUP;
  localparam int GRP_BITS  = gha_pkg::IDX_BITS - LOW_BITS;

  logic [NGROUPS-1:0]  grp_any;
  logic [LOW_BITS-1:0] grp_low [NGROUPS];
  logic                any;
  logic [GRP_BITS-1:0] grp_sel;

  // Lowest free bit inside each group of eight.
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_any[g] = 1'b0;
      grp_low[g] = '0;
      for (int b = GROUP - 1; b >= 0; b--) begin
        if (!live[g*GROUP + b]) begin
          grp_any[g] = 1'b1;
          grp_low[g] = LOW_BITS'(b);
        end
      end
    end
  end

  // Lowest group that holds a free slot.
  always_comb begin
    any     = 1'b0;
    grp_sel = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        any     = 1'b1;
        grp_sel = GRP_BITS'(g);
      end
    end
  end

  assign free.none = !any;
  assign free.idx  = {grp_sel, grp_low[grp_sel]};

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out slot handles from a fixed pool and takes them back, keeping a
// generation count for every slot.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command per transaction: an allocate, which
//   claims the lowest free slot and stores the type mask with the alive bit
//   set, or a release, which frees a live slot and bumps its generation.
//   The rsp channel returns exactly one result per command, in order.
//   A command is accepted when req_valid is high and req_stall is low; a
//   result is taken when rsp_valid is high and rsp_stall is low.
//   From acceptance, the command passes through the busy state and then
//   the output register, which raises rsp_valid when the output is free.
//   No new command is taken while one is busy: the slot memory is read
//   first, then written back with the live map updated, from which the
//   next free slot is encoded for the following command.
//   A stalled result waits in the output register; one further command may
//   still be taken, its result parking in a holding stage, after which
//   req_stall stays high until the output drains.
//   Synchronous reset frees every slot, zeroes all generations through
//   per-slot valid bits and clears the live count; no clearing pass is run.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  gha_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output gha_pkg::rsp_t rsp
);

  localparam int IDX_BITS   = gha_pkg::IDX_BITS;
  localparam int COUNT_BITS = gha_pkg::COUNT_BITS;

  // Control state.
  logic                      busy;
  logic                      pend_valid;
  logic [gha_pkg::SLOTS-1:0] live_map;
  logic [gha_pkg::SLOTS-1:0] live_map_next;
  logic [gha_pkg::SLOTS-1:0] gen_valid;
  logic [COUNT_BITS-1:0]     live_total;
  logic [COUNT_BITS-1:0]     live_total_next;
  gha_pkg::free_t            free_q;
  gha_pkg::free_t            free_next;

  // Command captured at acceptance.
  gha_pkg::action_t              act_q;
  logic [IDX_BITS-1:0]           idx_q;
  logic [gha_pkg::MASK_BITS-1:0] tmask_q;
  logic                          full_q;

  // Memory and result signals.
  logic                  req_accept;
  logic                  rsp_take;
  logic [IDX_BITS-1:0]   raddr;
  gha_pkg::entry_t       rd_entry;
  gha_pkg::entry_t       wr_entry;
  logic                  wr_en;
  logic [gha_pkg::GEN_BITS-1:0]  gen_cur;
  logic [gha_pkg::MASK_BITS-1:0] mask_new;
  gha_pkg::rsp_t         result;
  gha_pkg::rsp_t         pend;

  assign req_accept = req_valid && !req_stall;
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign req_stall  = busy || pend_valid;

  // The slot to read: the encoded free slot for an allocate, else the named one.
  assign raddr = (req.action == gha_pkg::ACTION_ALLOC) ? free_q.idx : req.slot_index;

  gha_ram #(
    .WIDTH ($bits(gha_pkg::entry_t)),
    .DEPTH (gha_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_q),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // Generation of a slot that was never written reads as zero.
  assign gen_cur  = gen_valid[idx_q] ? rd_entry.gen : '0;
  assign mask_new = tmask_q | gha_pkg::ALIVE_MASK;

  // While busy with a command: modify the entry and form the result.
  always_comb begin
    live_map_next   = live_map;
    live_total_next = live_total;
    wr_en           = 1'b0;
    wr_entry        = rd_entry;
    result.status            = gha_pkg::STATUS_OK;
    result.handle_index      = '0;
    result.handle_generation = '0;
    result.stored_mask       = '0;
    if (busy) begin
      unique case (act_q)
        gha_pkg::ACTION_ALLOC: begin
          if (full_q) begin
            result.status = gha_pkg::STATUS_FULL;
          end else begin
            live_map_next[idx_q]     = 1'b1;
            live_total_next          = live_total + 1'b1;
            wr_en                    = 1'b1;
            wr_entry.gen             = gen_cur;
            wr_entry.mask            = mask_new;
            result.handle_index      = idx_q;
            result.handle_generation = gen_cur;
            result.stored_mask       = mask_new;
          end
        end
        gha_pkg::ACTION_RELEASE: begin
          if (!live_map[idx_q]) begin
            result.status = gha_pkg::STATUS_NOT_LIVE;
          end else begin
            live_map_next[idx_q]     = 1'b0;
            live_total_next          = live_total - 1'b1;
            wr_en                    = 1'b1;
            wr_entry.gen             = gen_cur + 1'b1;
            wr_entry.mask            = rd_entry.mask;
            result.handle_index      = idx_q;
            result.handle_generation = gen_cur + 1'b1;
            result.stored_mask       = rd_entry.mask;
          end
        end
        default: begin
          result.status = gha_pkg::STATUS_OK;
        end
      endcase
    end
    result.live_count = live_total_next;
  end

  // Next free slot, encoded from the updated live map.
  gha_free_finder u_free_finder (
    .live (live_map_next),
    .free (free_next)
  );

  // Sequencing, live map and generation valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      live_map   <= '0;
      gen_valid  <= '0;
      live_total <= '0;
      free_q     <= '0;
    end else begin
      busy       <= req_accept;
      live_map   <= live_map_next;
      live_total <= live_total_next;
      free_q     <= free_next;
      if (wr_en) begin
        gen_valid[idx_q] <= 1'b1;
      end
    end
  end

  // Capture of the accepted command.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      act_q   <= req.action;
      idx_q   <= raddr;
      tmask_q <= req.type_mask;
      full_q  <= free_q.none;
    end
  end

  // Output register and holding stage: control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (busy) begin
      if (!rsp_valid || rsp_take) begin
        rsp_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (pend_valid && rsp_take) begin
      pend_valid <= 1'b0;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register and holding stage: payload.
  always_ff @(posedge clk) begin
    if (busy) begin
      if (!rsp_valid || rsp_take) begin
        rsp <= result;
      end else begin
        pend <= result;
      end
    end else if (pend_valid && rsp_take) begin
      rsp <= pend;
    end
  end

`ifndef NO_ASSERTIONS
  // The live count always matches the number of live slots.
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    live_total == COUNT_BITS'($countones(live_map)))
    else $error("live count differs from live map population");

  // The encoded free slot is really free whenever the pool is not full.
  a_free_is_free: assert property (@(posedge clk) disable iff (rst)
    !busy && !free_q.none |-> !live_map[free_q.idx])
    else $error("encoded free slot is live");

  // The pool reads as full only when every slot is live.
  a_full_means_all_live: assert property (@(posedge clk) disable iff (rst)
    !busy && free_q.none |-> live_total == COUNT_BITS'(gha_pkg::SLOTS))
    else $error("pool full with free slots left");

  // A held result only exists behind a waiting output.
  a_pend_behind_output: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> rsp_valid)
    else $error("holding stage filled while output is empty");
`endif

endmodule

// ===== dv/generational_handle_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// handle_result_checker
// Watches both channels of the handle allocator. Every accepted command is
// run through a local model of the slot pool, and every accepted response is
// compared field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module handle_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  gha_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  gha_pkg::rsp_t rsp,
  output int            errors,
  output int            pending,
  output int            checked,
  output int            full_seen,
  output int            miss_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = gha_pkg::SLOTS;
  localparam int GEN_BITS   = gha_pkg::GEN_BITS;
  localparam int MASK_BITS  = gha_pkg::MASK_BITS;
  localparam int IDX_BITS   = gha_pkg::IDX_BITS;
  localparam int COUNT_BITS = gha_pkg::COUNT_BITS;

  // Local copy of the slot pool.
  logic                  slot_live  [SLOTS];
  logic [GEN_BITS-1:0]   slot_gen   [SLOTS];
  logic [MASK_BITS-1:0]  slot_tmask [SLOTS];
  logic [COUNT_BITS-1:0] live_slots;

  // Responses predicted but not yet returned, oldest first.
  gha_pkg::rsp_t handles_due[$];
  gha_pkg::rsp_t oldest_due;

  initial begin
    errors    = 0;
    pending   = 0;
    checked   = 0;
    full_seen = 0;
    miss_seen = 0;
  end

  // Applies one command to the local pool and returns the response it earns.
  function automatic gha_pkg::rsp_t allocate_or_release(input gha_pkg::req_t cmd);
    gha_pkg::rsp_t answer;
    int            slot;
    answer = '0;
    slot   = -1;
    if (cmd.action == gha_pkg::ACTION_ALLOC) begin
      // The lowest free slot wins.
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_live[i]) slot = i;
      end
      if (slot < 0) begin
        answer.status = gha_pkg::STATUS_FULL;
      end else begin
        slot_live[slot]          = 1'b1;
        slot_tmask[slot]         = cmd.type_mask | gha_pkg::ALIVE_MASK;
        live_slots               = live_slots + 1'b1;
        answer.status            = gha_pkg::STATUS_OK;
        answer.handle_index      = IDX_BITS'(slot);
        answer.handle_generation = slot_gen[slot];
        answer.stored_mask       = slot_tmask[slot];
      end
    end else begin
      slot = int'(cmd.slot_index);
      if (!slot_live[slot]) begin
        answer.status = gha_pkg::STATUS_NOT_LIVE;
      end else begin
        // The mask stays as it was; only the generation moves on.
        slot_live[slot]          = 1'b0;
        slot_gen[slot]           = slot_gen[slot] + 1'b1;
        live_slots               = live_slots - 1'b1;
        answer.status            = gha_pkg::STATUS_OK;
        answer.handle_index      = cmd.slot_index;
        answer.handle_generation = slot_gen[slot];
        answer.stored_mask       = slot_tmask[slot];
      end
    end
    answer.live_count = live_slots;
    return answer;
  endfunction

  // Reports one bad response; only the first ten are printed.
  task automatic report_bad(input string why, input gha_pkg::rsp_t want,
                            input gha_pkg::rsp_t got);
    if (errors < 10) begin
      $display("%0t: response %0d %s", $realtime, checked, why);
      $display("  expected st=%0d idx=%0d gen=%h mask=%h live=%0d",
               want.status, want.handle_index, want.handle_generation,
               want.stored_mask, want.live_count);
      $display("  got      st=%0d idx=%0d gen=%h mask=%h live=%0d",
               got.status, got.handle_index, got.handle_generation,
               got.stored_mask, got.live_count);
    end
    errors++;
  endtask

  // Compare responses first, then predict for a command taken at this edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_gen[i]   = '0;
        slot_tmask[i] = '0;
      end
      live_slots = '0;
      handles_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (handles_due.size() == 0) begin
          report_bad("with nothing outstanding", '0, rsp);
        end else begin
          oldest_due = handles_due.pop_front();
          if (rsp.status            !== oldest_due.status ||
              rsp.handle_index      !== oldest_due.handle_index ||
              rsp.handle_generation !== oldest_due.handle_generation ||
              rsp.stored_mask       !== oldest_due.stored_mask ||
              rsp.live_count        !== oldest_due.live_count) begin
            report_bad("mismatch", oldest_due, rsp);
          end
          if (oldest_due.status == gha_pkg::STATUS_FULL) full_seen++;
          if (oldest_due.status == gha_pkg::STATUS_NOT_LIVE) miss_seen++;
        end
        checked++;
      end
      if (req_valid && !req_stall) begin
        handles_due.push_back(allocate_or_release(req));
      end
    end
    pending <= handles_due.size();
  end

endmodule

// ===== dv/generational_handle_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator_tb
// Drives allocate and release commands into the handle allocator in bursts,
// stalls the response side on its own pattern, and leaves the checking to
// handle_result_checker. Covers empty and full pools, misses, mask edge
// values and a final drain of every live slot.
// ----------------------------------------------------------------------------
module generational_handle_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = gha_pkg::SLOTS;
  localparam int MASK_BITS    = gha_pkg::MASK_BITS;
  localparam int IDX_BITS     = gha_pkg::IDX_BITS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 100;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  gha_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  gha_pkg::rsp_t rsp;

  int errors;
  int pending;
  int checked;
  int full_seen;
  int miss_seen;

  // Stimulus-side view of which slots are taken, used to aim releases.
  logic [SLOTS-1:0] occupied = '0;
  int               sent     = 0;
  logic             no_stall = 1'b0;

  // Receiver stall pattern state.
  int stall_mode = 0;
  int stall_left = 0;

  always #10 clk = ~clk;

  generational_handle_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  handle_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .full_seen (full_seen),
    .miss_seen (miss_seen)
  );

  // Response stall: segments of no stall, light, heavy and solid stalling.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(3, 20) : $urandom_range(10, 60);
    end
    stall_left--;
    if (no_stall) begin
      rsp_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 99) < 30);
        2: rsp_stall <= ($urandom_range(0, 99) < 70);
        default: rsp_stall <= 1'b1;
      endcase
    end
  end

  // Presents one command and holds it until the allocator takes it.
  task automatic send(input gha_pkg::req_t cmd);
    req       <= cmd;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  // Builds a command, tracks its effect on the occupied map, and sends it.
  task automatic issue(input gha_pkg::action_t act, input logic [IDX_BITS-1:0] idx,
                       input logic [MASK_BITS-1:0] tmask);
    gha_pkg::req_t cmd;
    int            lowest;
    cmd.action     = act;
    cmd.slot_index = idx;
    cmd.type_mask  = tmask;
    lowest         = -1;
    if (act == gha_pkg::ACTION_ALLOC) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!occupied[i]) lowest = i;
      end
      if (lowest >= 0) occupied[lowest] = 1'b1;
    end else begin
      occupied[idx] = 1'b0;
    end
    send(cmd);
  endtask

  function automatic logic [MASK_BITS-1:0] pick_mask();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return MASK_BITS'($urandom);
  endfunction

  // Mostly a live slot, found by scanning from a random start; else any slot.
  function automatic logic [IDX_BITS-1:0] pick_release_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 99) < 80) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (occupied[(start + k) % SLOTS]) return IDX_BITS'((start + k) % SLOTS);
      end
    end
    return IDX_BITS'(start);
  endfunction

  // Drops valid for the requested idle gap, with noise on the payload.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      req       <= gha_pkg::req_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    int gap;
    int alloc_pct;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty pool, mask extremes, release and reuse.
    issue(gha_pkg::ACTION_RELEASE, 6'd0,  16'h0000);
    issue(gha_pkg::ACTION_RELEASE, 6'd63, 16'hFFFF);
    issue(gha_pkg::ACTION_ALLOC,   6'd63, 16'h0000);
    issue(gha_pkg::ACTION_ALLOC,   6'd0,  16'hFFFF);
    idle_gap(3);
    issue(gha_pkg::ACTION_ALLOC,   6'd21, 16'hFFFE);
    issue(gha_pkg::ACTION_ALLOC,   6'd42, 16'h5554);
    issue(gha_pkg::ACTION_ALLOC,   6'd0,  16'hAAAA);
    issue(gha_pkg::ACTION_RELEASE, 6'd1,  16'h0000);
    issue(gha_pkg::ACTION_RELEASE, 6'd1,  16'hFFFF);
    idle_gap(1);
    issue(gha_pkg::ACTION_ALLOC,   6'd0,  16'h8000);
    issue(gha_pkg::ACTION_RELEASE, 6'd0,  16'h1234);
    issue(gha_pkg::ACTION_RELEASE, 6'd2,  16'h0000);
    issue(gha_pkg::ACTION_RELEASE, 6'd63, 16'h0000);
    issue(gha_pkg::ACTION_ALLOC,   6'd0,  16'h0001);
    issue(gha_pkg::ACTION_ALLOC,   6'd0,  16'h7FFF);
    issue(gha_pkg::ACTION_RELEASE, 6'd4,  16'h0000);
    issue(gha_pkg::ACTION_RELEASE, 6'd3,  16'h0000);
    idle_gap(2);

    // Random: phases that fill the pool, mix, then drain it, in bursts.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ((n / PHASE_ITEMS) % 3)
        0: alloc_pct = 85;
        1: alloc_pct = 50;
        default: alloc_pct = 15;
      endcase
      if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(30, 60);
        gap   = 0;
      end else begin
        burst = $urandom_range(1, 12);
        gap   = $urandom_range(0, 8);
      end
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 99) < alloc_pct)
          issue(gha_pkg::ACTION_ALLOC, IDX_BITS'($urandom), pick_mask());
        else
          issue(gha_pkg::ACTION_RELEASE, pick_release_slot(), MASK_BITS'($urandom));
        n++;
      end
      idle_gap(gap);
    end

    // Final drain: release every slot still live, with the output unstalled.
    no_stall <= 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      if (occupied[s]) begin
        issue(gha_pkg::ACTION_RELEASE, IDX_BITS'(s), MASK_BITS'($urandom));
      end
    end
    no_stall <= 1'b0;
    req_valid <= 1'b0;
    @(posedge clk);

    // Drain outstanding responses, then allow for latency.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d commands through fill, mixed and drain phases of the pool.", sent);
    $display("Checked %0d responses: %0d pool-full, %0d release misses.",
             checked, full_seen, miss_seen);
    if (errors == 0 && pending == 0) begin
      $display("generational_handle_allocator_tb: done, clean");
    end else begin
      $display("generational_handle_allocator_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30ms;
    $display("Timed out with %0d responses outstanding.", pending);
    $display("generational_handle_allocator_tb: done, errors");
    $finish;
  end

endmodule
